### hdl/sls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sync LED sequencer package
// Widths, register indexes, operation codes and reset values used by the
// sequencer.
// ----------------------------------------------------------------------------
package sls_pkg;

    localparam int TIME_W   = 32;
    localparam int PERIOD_W = 26;
    localparam int BLINKS_W = 8;
    localparam int COUNT_W  = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = PERIOD_W;

    typedef logic [TIME_W-1:0]   time_us_t;
    typedef logic [PERIOD_W-1:0] period_t;
    typedef logic [BLINKS_W-1:0] blinks_t;
    typedef logic [COUNT_W-1:0]  count_t;

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_TRIGGER = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_START_STOP_HALF_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_HALF_PERIOD      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_STOP_BLINKS      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ON_LEVEL               = 2'd3;

    localparam period_t RST_START_STOP_HALF_PERIOD = period_t'(50000);
    localparam period_t RST_BLINK_HALF_PERIOD      = period_t'(500000);
    localparam blinks_t RST_START_STOP_BLINKS      = blinks_t'(3);
    localparam logic    RST_ON_LEVEL               = 1'b1;

endpackage

### hdl/sls_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sync LED sequencer channels
// Valid/ready channels for input items and for result items.
// ----------------------------------------------------------------------------
interface sls_item_if;
    logic valid;
    logic ready;
    logic opcode;
    logic [31:0] now_us;
    logic default_pin_level;

    modport source (output valid, output opcode, output now_us,
                    output default_pin_level, input ready);
    modport sink   (input valid, input opcode, input now_us,
                    input default_pin_level, output ready);
endinterface

interface sls_result_if;
    logic valid;
    logic ready;
    logic led_on;
    logic led_level;
    logic is_blinking;

    modport source (output valid, output led_on, output led_level,
                    output is_blinking, input ready);
    modport sink   (input valid, input led_on, input led_level,
                    input is_blinking, output ready);
endinterface

### hdl/sync_led_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sync LED sequencer
// Drives a synchronization LED from a stream of tick and trigger items.
// ----------------------------------------------------------------------------
// Usage:
// Each beat on the item channel is either a tick, carrying the current
// microsecond timestamp and the sampled default-level pin, or a trigger,
// which toggles the start-stop and blink modes and clears the change count.
// Every item yields exactly one beat on the result channel, carrying the
// LED on flag, the driven LED level and the blinking status.
// The state update is registered: an item's result is valid after the edge
// that accepts it. A new item can be accepted in every cycle while the result
// channel is ready, so throughput is one item per cycle, set by the single
// result register that follows the elapsed-time compare. When the receiver
// stalls, the result register holds its beat and the item channel takes one
// more item only once that beat leaves. Reset clears the result register and
// restores all configuration registers and LED state to their reset values; no
// clearing pass is needed. Configuration is written through cfg_we, cfg_index
// and cfg_data, by the user only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module sync_led_sequencer
    import sls_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    sls_item_if.sink              item,
    sls_result_if.source          result
);

    period_t  ss_period_reg;
    period_t  blink_period_reg;
    blinks_t  ss_blinks_reg;
    logic     on_level_reg;

    time_us_t last_change_reg,  last_change_next;
    period_t  cur_period_reg,   cur_period_next;
    logic     led_state_reg,    led_state_next;
    logic     led_on_flag_reg,  led_on_flag_next;
    logic     idle_level_reg,   idle_level_next;
    count_t   change_count_reg, change_count_next;
    logic     seq_active_reg,   seq_active_next;
    logic     blink_active_reg, blink_active_next;
    logic     blinking_reg,     blinking_next;

    logic     out_valid_reg;
    logic     accept;
    time_us_t elapsed;
    count_t   target;
    logic     led_work;

    assign item.ready = !out_valid_reg || result.ready;
    assign accept     = item.valid && item.ready;

    assign result.valid       = out_valid_reg;
    assign result.led_on      = led_on_flag_reg;
    assign result.led_level   = led_state_reg;
    assign result.is_blinking = blinking_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ss_period_reg    <= RST_START_STOP_HALF_PERIOD;
            blink_period_reg <= RST_BLINK_HALF_PERIOD;
            ss_blinks_reg    <= RST_START_STOP_BLINKS;
            on_level_reg     <= RST_ON_LEVEL;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_START_STOP_HALF_PERIOD: ss_period_reg    <= cfg_data;
                REG_BLINK_HALF_PERIOD:      blink_period_reg <= cfg_data;
                REG_START_STOP_BLINKS:      ss_blinks_reg    <= cfg_data[BLINKS_W-1:0];
                REG_ON_LEVEL:               on_level_reg     <= cfg_data[0];
                default:                    ;
            endcase
        end
    end

    assign elapsed = item.now_us - last_change_reg;
    assign target  = {1'b0, ss_blinks_reg, 1'b0}
                   + count_t'(idle_level_reg == on_level_reg);

    always_comb
    begin
        last_change_next  = last_change_reg;
        cur_period_next   = cur_period_reg;
        led_state_next    = led_state_reg;
        led_on_flag_next  = led_on_flag_reg;
        idle_level_next   = idle_level_reg;
        change_count_next = change_count_reg;
        seq_active_next   = seq_active_reg;
        blink_active_next = blink_active_reg;
        blinking_next     = blinking_reg;
        led_work          = led_state_reg;

        if (item.opcode == OP_TRIGGER)
        begin
            seq_active_next   = !seq_active_reg;
            blink_active_next = !blink_active_reg;
            change_count_next = '0;
        end
        else if (elapsed >= {{(TIME_W-PERIOD_W){1'b0}}, cur_period_reg})
        begin
            last_change_next = item.now_us;
            if (seq_active_reg)
            begin
                if (cur_period_reg == blink_period_reg)
                begin
                    cur_period_next = ss_period_reg;
                    led_work        = on_level_reg;
                end
                led_work          = !led_work;
                change_count_next = change_count_reg + count_t'(1);
                if (change_count_next == target)
                begin
                    seq_active_next = 1'b0;
                end
                blinking_next = 1'b1;
            end
            else if (blink_active_reg)
            begin
                if (cur_period_reg == ss_period_reg)
                begin
                    cur_period_next = blink_period_reg;
                end
                led_work = !led_work;
            end
            else
            begin
                blinking_next = 1'b0;
                led_work      = idle_level_reg;
            end
            led_state_next   = led_work;
            led_on_flag_next = (led_work == on_level_reg);
            idle_level_next  = item.default_pin_level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_change_reg  <= '0;
            cur_period_reg   <= RST_BLINK_HALF_PERIOD;
            led_state_reg    <= RST_ON_LEVEL;
            led_on_flag_reg  <= 1'b1;
            idle_level_reg   <= RST_ON_LEVEL;
            change_count_reg <= '0;
            seq_active_reg   <= 1'b0;
            blink_active_reg <= 1'b0;
            blinking_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                last_change_reg  <= last_change_next;
                cur_period_reg   <= cur_period_next;
                led_state_reg    <= led_state_next;
                led_on_flag_reg  <= led_on_flag_next;
                idle_level_reg   <= idle_level_next;
                change_count_reg <= change_count_next;
                seq_active_reg   <= seq_active_next;
                blink_active_reg <= blink_active_next;
                blinking_reg     <= blinking_next;
                out_valid_reg    <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTH
    a_result_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted item produced no result beat");

    a_trigger_flips_modes: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.opcode == OP_TRIGGER |=>
            seq_active_reg != $past(seq_active_reg)
            && blink_active_reg != $past(blink_active_reg)
            && change_count_reg == '0)
        else $error("trigger did not flip modes and clear the count");

    a_state_holds_without_item: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(led_state_reg) && $stable(last_change_reg)
            && $stable(change_count_reg))
        else $error("LED state changed without an accepted item");

    a_sequence_step_blinks: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.opcode == OP_TICK && seq_active_reg
            && last_change_next == item.now_us
            && elapsed >= {{(TIME_W-PERIOD_W){1'b0}}, cur_period_reg}
            |=> blinking_reg)
        else $error("start-stop step did not set the blinking status");
`endif

endmodule
